// ===== hdl/tsn_pkg.sv =====
// package of types and constants for the tactile sample normalizer
package tsn_pkg;

  localparam int WEIGHT_BITS = 16;

  typedef enum logic [2:0] {
    MODE_RAW_CUR      = 3'd0,
    MODE_RAW_MEAN     = 3'd1,
    MODE_ABS_CUR      = 3'd2,
    MODE_ABS_MEAN     = 3'd3,
    MODE_DYN_CUR      = 3'd4,
    MODE_DYN_MEAN     = 3'd5,
    MODE_DYN_CUR_REL  = 3'd6,
    MODE_DYN_MEAN_REL = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    REG_MEAN_WEIGHT   = 3'd0,
    REG_RANGE_WEIGHT  = 3'd1,
    REG_RELEASE_DECAY = 3'd2,
    REG_ABS_MIN_START = 3'd3,
    REG_ABS_MAX_START = 3'd4,
    REG_OUTPUT_MODE   = 3'd5
  } reg_addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOW,
    ST_HIGH,
    ST_MEAN,
    ST_DEC,
    ST_REL,
    ST_OUT,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/tsn_if.sv =====
// valid/ready channel interfaces for input and result words
interface tsn_in_if #(parameter int SAMPLE_BITS = 12);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   sample_ok;
  modport source (output valid, sample, sample_ok, input ready);
  modport sink (input valid, sample, sample_ok, output ready);
endinterface

interface tsn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] level;
  logic               level_valid;
  logic               releasing;
  modport source (output valid, level, level_valid, releasing, input ready);
  modport sink (input valid, level, level_valid, releasing, output ready);
endinterface

// ===== hdl/tsn_divider.sv =====
// restoring divider, one quotient bit per cycle, saturating q1.15 result
module tsn_divider import tsn_pkg::*; #(
  parameter int W = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         busy,
  output logic         done,
  output logic [15:0]  quot
);
  localparam int CW = $clog2(W + 16);
  logic [W+15:0] rem;
  logic [W+15:0] dividend;
  logic [16:0]   q;
  logic [CW-1:0] cnt;
  logic [W+16:0] trial;

  // quotient is saturated at 2^16: only 17 bits of it are kept
  always_comb trial = {rem[W+14:0], dividend[W+15]} - {17'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W + 16);
        rem  <= '0;
        dividend <= {num, 16'd0} >> 1;
        q    <= '0;
      end else if (busy) begin
        if (!trial[W+16]) begin
          rem <= trial[W+15:0];
          q   <= (q[16] ? q : {q[15:0], 1'b1});
        end else begin
          rem <= {rem[W+14:0], dividend[W+15]};
          q   <= (q[16] ? q : {q[15:0], 1'b0});
        end
        dividend <= dividend << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // 16 quotient bits plus an overflow flag; magnitude saturates at 32768
  always_comb quot = (q[16] || q[15]) ? 16'h8000 : q[15:0];
endmodule

// ===== hdl/tactile_sample_normalizer_unit.sv =====
// top level of the tactile sample normalizer
// One word in, one word out. A valid sample updates the absolute and sliding
// ranges, the exponential mean and the release tracker, then the selected
// mode value is formed. Arithmetic runs through one shared 28x16 multiplier
// (steps low, high, mean, decay) and a restoring divider that gives one
// quotient bit per cycle for the normalized modes. The block takes no new
// word until the result word has been taken. The config port is APB-style;
// writes are expected only while the block is idle.
module tactile_sample_normalizer_unit import tsn_pkg::*; #(
  parameter int SAMPLE_BITS = 12,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  tsn_in_if.sink      in_ch,
  tsn_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int QW = SAMPLE_BITS + FRAC_BITS;
  localparam int SB = SAMPLE_BITS;

  // configuration registers
  logic [15:0]   mean_weight, range_weight, release_decay;
  logic [SB-1:0] abs_min_start, abs_max_start;
  logic [2:0]    output_mode;

  // algorithm state
  logic [SB-1:0] abs_low, abs_high, last_sample;
  logic [QW-1:0] dyn_low, dyn_high, running_mean, release_level;
  logic          release_active, have_sample;

  state_t state, state_next;
  logic [SB-1:0] x;
  logic          x_ok;
  logic [QW-1:0] xq;

  // shared multiplier
  logic [QW-1:0]   mul_a;
  logic [15:0]     mul_w;
  logic [QW+15:0]  mul_p;
  logic [QW-1:0]   mul_r;
  logic [QW-1:0]   dec;

  // divider
  logic          div_start, div_busy, div_done;
  logic [QW-1:0] div_num, div_den;
  logic [15:0]   div_q;
  logic [15:0]   div_mag;
  logic          neg;
  logic          num_neg;

  logic signed [15:0] level;
  logic          level_valid, out_valid;

  wire pwr = psel && penable && pwrite;
  wire [2:0] reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_MEAN_WEIGHT:   prdata = {16'd0, mean_weight};
      REG_RANGE_WEIGHT:  prdata = {16'd0, range_weight};
      REG_RELEASE_DECAY: prdata = {16'd0, release_decay};
      REG_ABS_MIN_START: prdata = 32'(abs_min_start);
      REG_ABS_MAX_START: prdata = 32'(abs_max_start);
      REG_OUTPUT_MODE:   prdata = {29'd0, output_mode};
      default:           prdata = '0;
    endcase
  end

  assign xq = {x, {FRAC_BITS{1'b0}}};

  // multiplier operand selection by sequencer step
  always_comb begin
    mul_a = '0;
    mul_w = '0;
    unique case (state)
      ST_LOW:  begin mul_a = xq - dyn_low;        mul_w = range_weight; end
      ST_HIGH: begin mul_a = dyn_high - xq;       mul_w = range_weight; end
      ST_MEAN: begin
        mul_a = (running_mean >= xq) ? running_mean - xq : xq - running_mean;
        mul_w = mean_weight;
      end
      ST_DEC:  begin mul_a = dyn_high - dyn_low;  mul_w = release_decay; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_w;
  assign mul_r = mul_p[QW+15:16];

  // release decision terms
  logic [SB-1:0] arange;
  logic [SB+3:0] rise10, fall10;
  logic          rise_big, fall_big;
  assign arange   = (abs_high >= abs_low) ? abs_high - abs_low : '0;
  assign rise10   = (SB+4)'(x - last_sample) * (SB+4)'(10);
  assign fall10   = (SB+4)'(last_sample - x) * (SB+4)'(10);
  assign rise_big = (x > last_sample) && (rise10 > (SB+4)'(arange));
  assign fall_big = (x < last_sample) && (fall10 > (SB+4)'(arange));

  // output operand selection
  logic [QW-1:0] lo, range, v, rounded;
  logic [QW:0]   diff;
  logic          rel_sel;
  always_comb begin
    if (output_mode == MODE_ABS_CUR || output_mode == MODE_ABS_MEAN) begin
      lo    = {abs_low, {FRAC_BITS{1'b0}}};
      range = (abs_high > abs_low) ? {abs_high - abs_low, {FRAC_BITS{1'b0}}} : '0;
    end else begin
      lo    = dyn_low;
      range = dyn_high - dyn_low;
    end
    rel_sel = (output_mode == MODE_DYN_CUR_REL || output_mode == MODE_DYN_MEAN_REL)
              && release_active;
    v = (output_mode == MODE_ABS_MEAN || output_mode == MODE_DYN_MEAN ||
         output_mode == MODE_DYN_MEAN_REL) ? running_mean : {last_sample, {FRAC_BITS{1'b0}}};
    diff = rel_sel ? {1'b0, release_level} - {1'b0, lo} : {1'b0, v} - {1'b0, lo};
    rounded = (running_mean + (QW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  end

  tsn_divider #(.W(QW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quot(div_q)
  );

  // quotient magnitude: 32768 only for a negative numerator, else 32767 at most
  always_comb div_mag = (!num_neg && div_q[15]) ? 16'd32767 : div_q;

  // sequencer: next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: if (in_ch.valid) begin
        state_next = ST_LOW;
      end
      ST_LOW: begin
        if (!x_ok) state_next = ST_OUT;
        else if (!have_sample) state_next = ST_OUT;
        else state_next = ST_HIGH;
      end
      ST_HIGH: state_next = ST_MEAN;
      ST_MEAN: state_next = ST_DEC;
      ST_DEC:  state_next = ST_REL;
      ST_REL:  state_next = ST_OUT;
      ST_OUT: begin
        if (have_sample && output_mode != MODE_RAW_CUR && output_mode != MODE_RAW_MEAN
            && range != '0) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DIV:  if (div_done) begin
        state_next = ST_DONE;
      end
      ST_DONE: if (out_ch.ready) begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign div_num = diff[QW] ? QW'(-diff) : diff[QW-1:0];
  assign div_den = range;

  assign in_ch.ready   = (state == ST_IDLE);
  assign out_ch.valid  = out_valid;
  assign out_ch.level  = level;
  assign out_ch.level_valid = level_valid;
  assign out_ch.releasing   = release_active;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_weight    <= 16'd45875;
      range_weight   <= 16'd65503;
      release_decay  <= 16'd3277;
      abs_min_start  <= '1;
      abs_max_start  <= '0;
      output_mode    <= MODE_ABS_CUR;
      abs_low        <= '1;
      abs_high       <= '0;
      dyn_low        <= '0;
      dyn_high       <= '0;
      last_sample    <= '0;
      running_mean   <= '0;
      release_level  <= '0;
      release_active <= 1'b0;
      have_sample    <= 1'b0;
      out_valid      <= 1'b0;
      level_valid    <= 1'b0;
      level          <= '0;
    end else begin
      if (pwr) begin
        unique case (reg_idx)
          REG_MEAN_WEIGHT:   mean_weight   <= pwdata[15:0];
          REG_RANGE_WEIGHT:  range_weight  <= pwdata[15:0];
          REG_RELEASE_DECAY: release_decay <= pwdata[15:0];
          REG_ABS_MIN_START: begin
            abs_min_start <= pwdata[SB-1:0];
            abs_low       <= pwdata[SB-1:0];
          end
          REG_ABS_MAX_START: begin
            abs_max_start <= pwdata[SB-1:0];
            abs_high      <= pwdata[SB-1:0];
          end
          REG_OUTPUT_MODE:   output_mode <= pwdata[2:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: if (in_ch.valid) begin
          x    <= in_ch.sample;
          x_ok <= in_ch.sample_ok;
        end
        ST_LOW: if (x_ok) begin
          if (x < abs_low)  abs_low  <= x;
          if (x > abs_high) abs_high <= x;
          if (!have_sample) begin
            dyn_low      <= xq;
            dyn_high     <= xq;
            running_mean <= xq;
            last_sample  <= x;
            have_sample  <= 1'b1;
          end else if (xq < dyn_low) begin
            // widened low: the sample is below the low, so low lands on the sample
            dyn_low <= xq;
          end else begin
            dyn_low <= xq - mul_r;
          end
        end
        ST_HIGH: begin
          if (xq > dyn_high) dyn_high <= xq;
          else               dyn_high <= xq + mul_r;
        end
        ST_MEAN: begin
          if (running_mean >= xq) running_mean <= xq + mul_r;
          else                    running_mean <= xq - mul_r;
        end
        ST_DEC: dec <= mul_r;
        ST_REL: begin
          if (release_active && rise_big) begin
            release_active <= 1'b0;
            release_level  <= '0;
          end else if (!release_active && fall_big) begin
            release_active <= 1'b1;
            release_level  <= {last_sample, {FRAC_BITS{1'b0}}};
          end else if (release_active) begin
            if ({1'b0, release_level} < {1'b0, dyn_low} + {1'b0, dec}) begin
              release_active <= 1'b0;
              release_level  <= '0;
            end else begin
              release_level <= release_level - dec;
            end
          end
          last_sample <= x;
        end
        ST_OUT: begin
          neg     <= diff[QW] ^ rel_sel;
          num_neg <= diff[QW];
          level_valid <= 1'b0;
          level       <= '0;
          if (have_sample) begin
            if (output_mode == MODE_RAW_CUR) begin
              level_valid <= 1'b1;
              level <= (QW'(last_sample) > QW'(32767)) ? 16'sd32767 : 16'(last_sample);
            end else if (output_mode == MODE_RAW_MEAN) begin
              level_valid <= 1'b1;
              level <= (rounded > QW'(32767)) ? 16'sd32767 : 16'(rounded);
            end
          end
          if (state_next == ST_DONE) out_valid <= 1'b1;
        end
        ST_DIV: if (div_done) begin
          level_valid <= 1'b1;
          // release flips the sign after the quotient is saturated
          if (neg) level <= 16'(-div_mag);
          else     level <= (div_mag[15]) ? 16'sd32767 : 16'(div_mag);
          out_valid <= 1'b1;
        end
        ST_DONE: if (out_ch.ready) out_valid <= 1'b0;
        default: ;
      endcase
    end
  end

  // assertions
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_DONE)) else $error("result outside done");
  a_rel_level_zero: assert property (@(posedge clk) disable iff (rst)
    !release_active |-> (release_level == '0)) else $error("stale release level");
  a_div_only_norm: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (range != '0)) else $error("divide by zero range");
  a_div_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIV)) else $error("divider busy outside divide");
endmodule
